FILE: rtl/vptw_pkg.sv
// vptw_pkg: shared types, constants and helpers for the vertex projection unit
// no dependencies
package vptw_pkg;

    localparam int unsigned FX_W      = 32;
    localparam int unsigned PROD_W    = 48;
    localparam int unsigned WIN_W     = 33;
    localparam int unsigned DIV_BITS  = 48;
    localparam int unsigned DMAG_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic signed [CFG_W-1:0] VP_X_RESET = 16'sd0;
    localparam logic signed [CFG_W-1:0] VP_Y_RESET = 16'sd0;
    localparam logic [CFG_W-1:0]        VP_W_RESET = 16'd1080;
    localparam logic [CFG_W-1:0]        VP_H_RESET = 16'd1731;

    localparam logic signed [FX_W:0] FX_ONE = 33'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VIEWPORT_X      = 2'd0,
        CFG_VIEWPORT_Y      = 2'd1,
        CFG_VIEWPORT_WIDTH  = 2'd2,
        CFG_VIEWPORT_HEIGHT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_POINT = 1'b1
    } mode_t;

    typedef logic signed [FX_W-1:0] fx_t;

    function automatic fx_t sat32(input logic signed [63:0] v);
        fx_t r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[FX_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/vptw_xform.sv
// vptw_xform: matrix stores, modelview and projection transforms, four stages
// depends on vptw_pkg
module vptw_xform
    import vptw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic                 in_mode,
    input  logic [4:0]           in_index,
    input  fx_t                  in_value,
    input  fx_t                  in_px,
    input  fx_t                  in_py,
    input  fx_t                  in_pz,
    output logic                 out_valid,
    output fx_t                  clip_x,
    output fx_t                  clip_y,
    output fx_t                  clip_z,
    output logic signed [WIN_W-1:0] clip_w
);

    fx_t mv_reg [16];
    fx_t pj_reg [16];

    logic                    a_vld_reg, a_pt_reg;
    logic [4:0]              a_idx_reg;
    fx_t                     a_val_reg;
    logic signed [PROD_W-1:0] a_prod_reg [12];
    fx_t                     a_tr_reg [4];

    logic                    b_vld_reg, b_pt_reg;
    logic [4:0]              b_idx_reg;
    fx_t                     b_val_reg;
    fx_t                     b_eye_reg [4];

    logic                    c_vld_reg;
    logic signed [PROD_W-1:0] c_prod_reg [12];
    fx_t                     c_ez_reg;

    logic                    d_vld_reg;
    fx_t                     d_clip_reg [3];
    logic signed [WIN_W-1:0] d_w_reg;

    logic signed [PROD_W-1:0] a_prod_next [12];
    fx_t                     b_eye_next [4];
    logic signed [PROD_W-1:0] c_prod_next [12];
    fx_t                     d_clip_next [3];
    fx_t                     pt [3];
    logic signed [63:0]      prod;
    logic signed [63:0]      acc;

    assign pt[0] = in_px;
    assign pt[1] = in_py;
    assign pt[2] = in_pz;

    always_comb
    begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod = mv_reg[c*4+r] * pt[c];
                a_prod_next[c*4+r] = prod[63:16];
            end
        end
        for (int r = 0; r < 4; r++) begin
            acc = 64'(a_tr_reg[r]) + 64'(a_prod_reg[r]) + 64'(a_prod_reg[4+r])
                + 64'(a_prod_reg[8+r]);
            b_eye_next[r] = sat32(acc);
        end
        // products kept row by row, four per clip row
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                prod = pj_reg[c*4+r] * b_eye_reg[c];
                c_prod_next[r*4+c] = prod[63:16];
            end
        end
        for (int r = 0; r < 3; r++) begin
            acc = 64'(c_prod_reg[r*4]) + 64'(c_prod_reg[r*4+1]) + 64'(c_prod_reg[r*4+2])
                + 64'(c_prod_reg[r*4+3]);
            d_clip_next[r] = sat32(acc);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) begin
                mv_reg[i] <= '0;
                pj_reg[i] <= '0;
            end
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (ce) begin
            if (in_valid && in_mode == MODE_LOAD && !in_index[4]) begin
                mv_reg[in_index[3:0]] <= in_value;
            end
            if (b_vld_reg && !b_pt_reg && b_idx_reg[4]) begin
                pj_reg[b_idx_reg[3:0]] <= b_val_reg;
            end
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg && b_pt_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            a_pt_reg  <= in_mode;
            a_idx_reg <= in_index;
            a_val_reg <= in_value;
            for (int i = 0; i < 12; i++) begin
                a_prod_reg[i] <= a_prod_next[i];
                c_prod_reg[i] <= c_prod_next[i];
            end
            for (int r = 0; r < 4; r++) begin
                a_tr_reg[r] <= mv_reg[12+r];
                b_eye_reg[r] <= b_eye_next[r];
            end
            b_pt_reg  <= a_pt_reg;
            b_idx_reg <= a_idx_reg;
            b_val_reg <= a_val_reg;
            c_ez_reg  <= b_eye_reg[2];
            for (int r = 0; r < 3; r++) begin
                d_clip_reg[r] <= d_clip_next[r];
            end
            d_w_reg <= -(WIN_W'(c_ez_reg));
        end
    end

    assign out_valid = d_vld_reg;
    assign clip_x    = d_clip_reg[0];
    assign clip_y    = d_clip_reg[1];
    assign clip_z    = d_clip_reg[2];
    assign clip_w    = d_w_reg;

endmodule

FILE: rtl/vptw_div_lane.sv
// vptw_div_lane: pipelined restoring divider, (num * 65536) / den toward zero, saturated
// one quotient bit per stage; depends on vptw_pkg
module vptw_div_lane
    import vptw_pkg::*;
(
    input  logic                    clk,
    input  logic                    ce,
    input  fx_t                     num,
    input  logic signed [WIN_W-1:0] den,
    output fx_t                     quot
);

    logic [DMAG_W-1:0]   rem_reg [DIV_BITS+1];
    logic [DIV_BITS-1:0] nq_reg  [DIV_BITS+1];
    logic [DMAG_W-1:0]   d_reg   [DIV_BITS+1];
    logic                neg_reg [DIV_BITS+1];
    fx_t                 quot_reg;

    logic [WIN_W-1:0]    num_mag;
    logic [WIN_W-1:0]    den_mag;
    logic signed [DIV_BITS+1:0] sq;

    assign num_mag = num[FX_W-1] ? WIN_W'(-(WIN_W'(num))) : WIN_W'(num);
    assign den_mag = den[WIN_W-1] ? WIN_W'(-den) : WIN_W'(den);

    always_ff @(posedge clk)
    begin
        if (ce) begin
            rem_reg[0] <= '0;
            nq_reg[0]  <= {num_mag[DMAG_W-1:0], 16'd0};
            d_reg[0]   <= den_mag[DMAG_W-1:0];
            neg_reg[0] <= num[FX_W-1] ^ den[WIN_W-1];
        end
    end

    for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
        logic [DMAG_W:0] trial;
        logic [DMAG_W:0] diff;
        assign trial = {rem_reg[k-1], nq_reg[k-1][DIV_BITS-1]};
        assign diff  = trial - {1'b0, d_reg[k-1]};
        always_ff @(posedge clk)
        begin
            if (ce) begin
                if (!diff[DMAG_W]) begin
                    rem_reg[k] <= diff[DMAG_W-1:0];
                end
                else begin
                    rem_reg[k] <= trial[DMAG_W-1:0];
                end
                nq_reg[k]  <= {nq_reg[k-1][DIV_BITS-2:0], ~diff[DMAG_W]};
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    assign sq = neg_reg[DIV_BITS] ? -(signed'({2'b00, nq_reg[DIV_BITS]}))
                                  : signed'({2'b00, nq_reg[DIV_BITS]});

    always_ff @(posedge clk)
    begin
        if (ce) begin
            quot_reg <= sat32(64'(sq));
        end
    end

    assign quot = quot_reg;

endmodule

FILE: rtl/vptw_viewport.sv
// vptw_viewport: viewport and depth mapping, two stages, holds the output register
// depends on vptw_pkg
module vptw_viewport
    import vptw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    ce,
    input  logic                    in_valid,
    input  logic                    in_zero,
    input  fx_t                     nx,
    input  fx_t                     ny,
    input  fx_t                     nz,
    input  logic signed [CFG_W-1:0] vp_x,
    input  logic signed [CFG_W-1:0] vp_y,
    input  logic [CFG_W-1:0]        vp_w,
    input  logic [CFG_W-1:0]        vp_h,
    output logic                    out_valid,
    output logic                    out_projected,
    output fx_t                     out_x,
    output fx_t                     out_y,
    output fx_t                     out_d
);

    logic                    m_vld_reg, m_zero_reg;
    logic signed [49:0]      m_x_reg, m_y_reg;
    fx_t                     m_d_reg;
    logic                    o_vld_reg, o_proj_reg;
    fx_t                     o_x_reg, o_y_reg, o_d_reg;

    logic signed [WIN_W-1:0] tx, ty, tz;
    logic signed [63:0]      sx, sy;

    assign tx = WIN_W'(nx) + FX_ONE;
    assign ty = WIN_W'(ny) + FX_ONE;
    assign tz = WIN_W'(nz) + FX_ONE;
    assign sx = 64'(m_x_reg >>> 1) + 64'($signed({vp_x, 16'd0}));
    assign sy = 64'(m_y_reg >>> 1) + 64'($signed({vp_y, 16'd0}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
        end
        else if (ce) begin
            m_vld_reg <= in_valid;
            o_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            m_zero_reg <= in_zero;
            m_x_reg    <= 50'(tx * signed'({1'b0, vp_w}));
            m_y_reg    <= 50'(ty * signed'({1'b0, vp_h}));
            m_d_reg    <= sat32(64'(tz >>> 1));
            o_proj_reg <= !m_zero_reg;
            o_x_reg    <= m_zero_reg ? '0 : sat32(sx);
            o_y_reg    <= m_zero_reg ? '0 : sat32(sy);
            o_d_reg    <= m_zero_reg ? '0 : m_d_reg;
        end
    end

    assign out_valid     = o_vld_reg;
    assign out_projected = o_proj_reg;
    assign out_x         = o_x_reg;
    assign out_y         = o_y_reg;
    assign out_d         = o_d_reg;

endmodule

FILE: rtl/vertex_project_to_window_unit.sv
// vertex_project_to_window_unit: top level of the vertex projection pipeline
// throughput one item per cycle while m_tready does not stall the output
// the divide (48 single-bit stages per coordinate) sets the depth
// the whole pipeline stalls together while a result waits on m_tready
// reset clears both matrix stores and valid bits and loads the viewport registers with their reset values at once
// depends on vptw_pkg, vptw_xform, vptw_div_lane, vptw_viewport
module vertex_project_to_window_unit
    import vptw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // entry_index, entry_value, point_x, point_y, point_z, zero fill
    input  logic [135:0]         s_tdata,
    // mode
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // projected, window_x, window_y, window_depth, zero fill
    output logic [103:0]         m_tdata
);

    localparam int unsigned DIV_LAT = DIV_BITS + 2;

    logic signed [CFG_W-1:0] vp_x_reg, vp_y_reg;
    logic [CFG_W-1:0]        vp_w_reg, vp_h_reg;

    logic       ce;
    logic       s0_vld_reg, s0_mode_reg;
    logic [4:0] s0_idx_reg;
    fx_t        s0_val_reg, s0_px_reg, s0_py_reg, s0_pz_reg;

    logic                    x_vld;
    fx_t                     cx, cy, cz;
    logic signed [WIN_W-1:0] cw;

    logic dv_reg [DIV_LAT];
    logic dz_reg [DIV_LAT];

    fx_t  qx, qy, qz;
    logic o_vld, o_proj;
    fx_t  o_x, o_y, o_d;

    assign ce       = !o_vld || m_tready;
    assign s_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vp_x_reg <= VP_X_RESET;
            vp_y_reg <= VP_Y_RESET;
            vp_w_reg <= VP_W_RESET;
            vp_h_reg <= VP_H_RESET;
        end
        else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_VIEWPORT_X:      vp_x_reg <= cfg_wdata;
                CFG_VIEWPORT_Y:      vp_y_reg <= cfg_wdata;
                CFG_VIEWPORT_WIDTH:  vp_w_reg <= cfg_wdata;
                CFG_VIEWPORT_HEIGHT: vp_h_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s0_vld_reg <= 1'b0;
            for (int i = 0; i < DIV_LAT; i++) begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (ce) begin
            s0_vld_reg <= s_tvalid;
            dv_reg[0]  <= x_vld;
            for (int i = 1; i < DIV_LAT; i++) begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce) begin
            s0_mode_reg <= s_tuser;
            s0_idx_reg  <= s_tdata[4:0];
            s0_val_reg  <= s_tdata[36:5];
            s0_px_reg   <= s_tdata[68:37];
            s0_py_reg   <= s_tdata[100:69];
            s0_pz_reg   <= s_tdata[132:101];
            dz_reg[0]   <= (cw == '0);
            for (int i = 1; i < DIV_LAT; i++) begin
                dz_reg[i] <= dz_reg[i-1];
            end
        end
    end

    vptw_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .ce        (ce),
        .in_valid  (s0_vld_reg),
        .in_mode   (s0_mode_reg),
        .in_index  (s0_idx_reg),
        .in_value  (s0_val_reg),
        .in_px     (s0_px_reg),
        .in_py     (s0_py_reg),
        .in_pz     (s0_pz_reg),
        .out_valid (x_vld),
        .clip_x    (cx),
        .clip_y    (cy),
        .clip_z    (cz),
        .clip_w    (cw)
    );

    vptw_div_lane u_div_x (.clk(clk), .ce(ce), .num(cx), .den(cw), .quot(qx));
    vptw_div_lane u_div_y (.clk(clk), .ce(ce), .num(cy), .den(cw), .quot(qy));
    vptw_div_lane u_div_z (.clk(clk), .ce(ce), .num(cz), .den(cw), .quot(qz));

    vptw_viewport u_viewport (
        .clk           (clk),
        .rst_n         (rst_n),
        .ce            (ce),
        .in_valid      (dv_reg[DIV_LAT-1]),
        .in_zero       (dz_reg[DIV_LAT-1]),
        .nx            (qx),
        .ny            (qy),
        .nz            (qz),
        .vp_x          (vp_x_reg),
        .vp_y          (vp_y_reg),
        .vp_w          (vp_w_reg),
        .vp_h          (vp_h_reg),
        .out_valid     (o_vld),
        .out_projected (o_proj),
        .out_x         (o_x),
        .out_y         (o_y),
        .out_d         (o_d)
    );

    assign m_tvalid = o_vld;
    assign m_tdata  = {7'd0, o_d, o_y, o_x, o_proj};

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for vertex_project_to_window_unit
// drives load and point items, predicts window coordinates in q16.16, checks each result
// depends on vptw_pkg and the unit rtl
module tb;
    import vptw_pkg::*;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic s_tvalid;
    logic s_tready;
    logic [135:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [103:0] m_tdata;

    vertex_project_to_window_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct packed {
        logic [136:0] bits;
    } item_t;

    item_t pending_items[$];
    logic [103:0] expected_windows[$];

    logic signed [63:0] mv_mat[16];
    logic signed [63:0] pj_mat[16];
    logic signed [63:0] vp_x;
    logic signed [63:0] vp_y;
    logic signed [63:0] vp_w;
    logic signed [63:0] vp_h;

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_item(input item_t it);
        pending_items = {pending_items, it};
    endfunction

    function automatic void add_expect(input logic [103:0] e);
        expected_windows = {expected_windows, e};
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] fx_quot(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        logic signed [127:0] n;
        logic signed [127:0] q;
        n = num;
        n = n * 128'sd65536;
        q = n / den;
        if (q > 128'sd2147483647)
        begin
            q = 128'sd2147483647;
        end
        else if (q < -128'sd2147483648)
        begin
            q = -128'sd2147483648;
        end
        return q[63:0];
    endfunction

    // update the matrix copy or compute the expected window result
    task automatic project_vertex(input item_t it);
        logic [4:0] idx;
        logic signed [63:0] pt[3];
        logic signed [63:0] eye[4];
        logic signed [63:0] clp[3];
        logic signed [63:0] acc;
        logic signed [63:0] w;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [63:0] nz;
        logic signed [63:0] wx;
        logic signed [63:0] wy;
        logic signed [63:0] wd;
        idx = it.bits[4:0];
        if (it.bits[136] == MODE_LOAD)
        begin
            if (idx < 16)
            begin
                mv_mat[idx] = $signed(it.bits[36:5]);
            end
            else
            begin
                pj_mat[idx - 16] = $signed(it.bits[36:5]);
            end
        end
        else
        begin
            pt[0] = $signed(it.bits[68:37]);
            pt[1] = $signed(it.bits[100:69]);
            pt[2] = $signed(it.bits[132:101]);
            for (int r = 0; r < 4; r++)
            begin
                acc = mv_mat[12 + r];
                for (int c = 0; c < 3; c++)
                begin
                    acc = acc + ((mv_mat[c * 4 + r] * pt[c]) >>> 16);
                end
                eye[r] = clamp32(acc);
            end
            for (int r = 0; r < 3; r++)
            begin
                acc = 0;
                for (int c = 0; c < 4; c++)
                begin
                    acc = acc + ((pj_mat[c * 4 + r] * eye[c]) >>> 16);
                end
                clp[r] = clamp32(acc);
            end
            w = -eye[2];
            if (w == 0)
            begin
                add_expect(104'd0);
            end
            else
            begin
                nx = fx_quot(clp[0], w);
                ny = fx_quot(clp[1], w);
                nz = fx_quot(clp[2], w);
                wx = clamp32((((nx + 65536) * vp_w) >>> 1) + vp_x * 65536);
                wy = clamp32((((ny + 65536) * vp_h) >>> 1) + vp_y * 65536);
                wd = clamp32((nz + 65536) >>> 1);
                add_expect({7'd0, wd[31:0], wy[31:0], wx[31:0], 1'b1});
            end
        end
    endtask

    task automatic write_viewport(input cfg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_VIEWPORT_X: vp_x = $signed(val);
            CFG_VIEWPORT_Y: vp_y = $signed(val);
            CFG_VIEWPORT_WIDTH: vp_w = {48'd0, val};
            default: vp_h = {48'd0, val};
        endcase
    endtask

    function automatic logic [31:0] rand_fx();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = 32'h7FFF_FFFF;
            2: v = 32'h8000_0000;
            3: v = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
            default: v = $signed($urandom_range(0, 256 << 16)) - (128 << 16);
        endcase
        return v;
    endfunction

    function automatic item_t load_item(input logic [4:0] idx, input logic [31:0] v);
        item_t it;
        it.bits = {MODE_LOAD, 3'd0, $urandom, $urandom, $urandom, v, idx};
        return it;
    endfunction

    function automatic item_t point_item(input logic [31:0] x, input logic [31:0] y,
                                         input logic [31:0] z);
        item_t it;
        logic [4:0] junk;
        junk = 5'($urandom);
        it.bits = {MODE_POINT, 3'd0, z, y, x, $urandom, junk};
        return it;
    endfunction

    // a perspective-like matrix set with random perturbation
    task automatic queue_scene();
        logic [31:0] m[32];
        for (int i = 0; i < 32; i++)
        begin
            m[i] = ($urandom_range(0, 3) == 0) ? rand_fx()
                 : $signed($urandom_range(0, 1 << 17)) - (1 << 16);
        end
        m[10] = 32'hFFFF_0000 + $urandom_range(0, 4096);
        m[14] = $signed($urandom_range(0, 20 << 16)) - (30 << 16);
        for (int i = 0; i < 32; i++)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                add_item(load_item(i[4:0], m[i]));
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_tvalid || expected_windows.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (70) @(posedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_t it;
                    it = pending_items.pop_front();
                    project_vertex(it);
                    s_tvalid <= 1'b1;
                    s_tdata <= it.bits[135:0];
                    s_tuser <= it.bits[136];
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_windows.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result %h", m_tdata);
                end
            end
            else
            begin
                logic [103:0] exp_w;
                exp_w = expected_windows.pop_front();
                if (exp_w[0] !== m_tdata[0] || exp_w[32:1] !== m_tdata[32:1]
                    || exp_w[64:33] !== m_tdata[64:33] || exp_w[96:65] !== m_tdata[96:65])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: proj %b/%b x %h/%h y %h/%h depth %h/%h",
                                 exp_w[0], m_tdata[0], exp_w[32:1], m_tdata[32:1],
                                 exp_w[64:33], m_tdata[64:33], exp_w[96:65], m_tdata[96:65]);
                    end
                end
            end
        end
    end

    initial
    begin
        #20000000;
        $display("** vertex_project_to_window_unit: FAILED **");
        $finish;
    end

    initial
    begin
        logic [15:0] vw_set[4];
        logic [15:0] vh_set[4];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        for (int i = 0; i < 16; i++)
        begin
            mv_mat[i] = 0;
            pj_mat[i] = 0;
        end
        vp_x = 0;
        vp_y = 0;
        vp_w = 1080;
        vp_h = 1731;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero matrices give zero w, then identity-like setup and extremes
        add_item(point_item(32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        add_item(load_item(5'd0, 32'h0001_0000));
        add_item(load_item(5'd5, 32'h0001_0000));
        add_item(load_item(5'd10, 32'h0001_0000));
        add_item(load_item(5'd15, 32'h0001_0000));
        add_item(load_item(5'd16, 32'h0001_0000));
        add_item(load_item(5'd21, 32'h0001_0000));
        add_item(load_item(5'd26, 32'h0001_0000));
        add_item(load_item(5'd31, 32'h8000_0000));
        add_item(point_item(32'h0000_8000, 32'hFFFF_8000, 32'hFFFE_0000));
        add_item(point_item(32'h0, 32'h0, 32'h0));
        add_item(point_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        add_item(point_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001));
        add_item(point_item(32'h0001_0000, 32'h0001_0000, 32'h8000_0000));
        add_item(load_item(5'd14, 32'h7FFF_FFFF));
        add_item(point_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
        add_item(load_item(5'd2, 32'h8000_0000));
        add_item(point_item(32'h0123_4567, 32'hFEDC_BA98, 32'h7FFF_0000));
        wait_drained();

        vw_set = '{16'd0, 16'hFFFF, 16'd640, 16'd1};
        vh_set = '{16'hFFFF, 16'd0, 16'd480, 16'd1731};
        for (int ph = 0; ph < 8; ph++)
        begin
            write_viewport(CFG_VIEWPORT_X, (ph == 1) ? 16'h8000 : (ph == 2) ? 16'h7FFF
                                          : 16'($urandom));
            write_viewport(CFG_VIEWPORT_Y, (ph == 1) ? 16'h7FFF : (ph == 2) ? 16'h8000
                                          : 16'($urandom));
            write_viewport(CFG_VIEWPORT_WIDTH, vw_set[ph % 4]);
            write_viewport(CFG_VIEWPORT_HEIGHT, vh_set[ph % 4]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < 80; n++)
            begin
                if (n % 40 == 0)
                begin
                    queue_scene();
                end
                if ($urandom_range(0, 15) == 0)
                begin
                    add_item(load_item(5'($urandom), rand_fx()));
                end
                add_item(point_item(rand_fx(), rand_fx(), rand_fx()));
                if (n == 60 && ph == 3)
                begin
                    // hold off until every result is back
                    while (pending_items.size() != 0 || s_tvalid ||
                           expected_windows.size() != 0)
                    begin
                        @(posedge clk);
                    end
                end
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_windows.size() == 0)
        begin
            $display("** vertex_project_to_window_unit: PASSED **");
        end
        else
        begin
            $display("** vertex_project_to_window_unit: FAILED **");
        end
        $finish;
    end
endmodule
